[rtl/core/m4mul_pkg.sv]
// m4mul_pkg: shared types for the 4x4 fixed-point matrix multiplier.
// Used by m4mul_cell and mat4_multiply; depends on nothing.

package m4mul_pkg;

   // Control tag that rides along the cell chain with each product element.
   typedef struct packed {
      logic valid;
      logic last;
   } cell_ctl_type;

endpackage

[rtl/core/mat4_multiply.sv]
// mat4_multiply: top level of the fixed-point 4x4 matrix multiplier.
// Depends on m4mul_pkg and m4mul_cell.
//
// Usage:
//   req_* stream: one word per element pair, A element in the low half of
//   req_tdata and B element above it, both signed Q16.16, in column-major
//   order. The sixteenth word carries req_tlast and starts the product.
//   rsp_* stream: sixteen words in column-major order, product element and
//   its index in rsp_tdata, the saturation flag in rsp_tuser, rsp_tlast on
//   the sixteenth.
// Timing:
//   Loading accepts one word per cycle. After the tlast word, req_tready stays
//   low while the product runs through a chain of MATRIX_DIM cells (one
//   multiply stage and one add stage each); each result passes both stages
//   of every cell in turn and then the output register, and results then
//   leave one per cycle while rsp_tready does not stall them.
//   req_tready returns once the final result sits in the output register.
// Reset clears the load position, the sequencer and all valid flags; the
// element stores keep whatever they held. A stall on rsp_tready freezes the
// whole cell chain; nothing is dropped.

module mat4_multiply #(
   parameter int ELEMENT_WIDTH = 32,
   parameter int FRACTION_BITS = 16,
   parameter int MATRIX_DIM    = 4
) (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic                                                  req_tvalid,
   output logic                                                  req_tready,
   // a_element, b_element
   input  logic [((2*ELEMENT_WIDTH+7)/8)*8-1:0]                  req_tdata,
   input  logic                                                  req_tlast,
   output logic                                                  rsp_tvalid,
   input  logic                                                  rsp_tready,
   // product_element, element_index
   output logic [((ELEMENT_WIDTH+$clog2(MATRIX_DIM*MATRIX_DIM)+7)/8)*8-1:0] rsp_tdata,
   // saturated
   output logic                                                  rsp_tuser,
   output logic                                                  rsp_tlast
);

   localparam int ROW_W   = $clog2(MATRIX_DIM);
   localparam int IDX_W   = $clog2(MATRIX_DIM*MATRIX_DIM);
   localparam int SUM_W   = 2*ELEMENT_WIDTH + $clog2(MATRIX_DIM);
   localparam int OUT_W   = ((ELEMENT_WIDTH+IDX_W+7)/8)*8;
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(MATRIX_DIM-1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MATRIX_DIM*MATRIX_DIM-1);

   typedef enum logic [2:0] {
      ST_LOAD  = 3'b001,
      ST_RUN   = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [ROW_W-1:0] ld_row_ff, ld_row_in, ld_col_ff, ld_col_in;
   logic [ROW_W-1:0] is_row_ff, is_row_in, is_col_ff, is_col_in;
   logic [IDX_W-1:0] is_idx_ff, is_idx_in;

   logic req_take, adv, issue_last, drain_done;

   logic signed [ELEMENT_WIDTH-1:0] a_word, b_word;

   m4mul_pkg::cell_ctl_type      ctl_chain [MATRIX_DIM+1];
   logic [ROW_W-1:0]             row_chain [MATRIX_DIM+1];
   logic [ROW_W-1:0]             col_chain [MATRIX_DIM+1];
   logic [IDX_W-1:0]             idx_chain [MATRIX_DIM+1];
   logic signed [SUM_W-1:0]      sum_chain [MATRIX_DIM+1];

   logic signed [SUM_W-1:0]         shifted;
   logic                            fits;
   logic signed [ELEMENT_WIDTH-1:0] clip_val;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ELEMENT_WIDTH-1:0] rsp_prod_ff, rsp_prod_in;
   logic [IDX_W-1:0]         rsp_idx_ff;
   logic                     rsp_sat_ff, rsp_sat_in, rsp_last_ff;

   assign a_word     = req_tdata[ELEMENT_WIDTH-1:0];
   assign b_word     = req_tdata[2*ELEMENT_WIDTH-1:ELEMENT_WIDTH];
   assign req_tready = (state_ff == ST_LOAD);
   assign req_take   = req_tvalid && req_tready;
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign issue_last = (is_idx_ff == LAST_IDX);
   assign drain_done = ctl_chain[MATRIX_DIM].valid && ctl_chain[MATRIX_DIM].last;

   // load position, issue counters and sequencer state
   always_comb begin
      ld_row_in = ld_row_ff;
      ld_col_in = ld_col_ff;
      is_row_in = is_row_ff;
      is_col_in = is_col_ff;
      is_idx_in = is_idx_ff;
      state_in  = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               if (req_tlast) begin
                  ld_row_in = '0;
                  ld_col_in = '0;
                  state_in  = ST_RUN;
               end else if (ld_row_ff == LAST_ROW) begin
                  ld_row_in = '0;
                  ld_col_in = (ld_col_ff == LAST_ROW) ? '0 : ld_col_ff + 1'b1;
               end else begin
                  ld_row_in = ld_row_ff + 1'b1;
               end
            end
            is_row_in = '0;
            is_col_in = '0;
            is_idx_in = '0;
         end
         ST_RUN: begin
            if (adv) begin
               is_idx_in = is_idx_ff + 1'b1;
               if (is_row_ff == LAST_ROW) begin
                  is_row_in = '0;
                  is_col_in = is_col_ff + 1'b1;
               end else begin
                  is_row_in = is_row_ff + 1'b1;
               end
               if (issue_last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (adv && drain_done) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         ld_row_ff <= '0;
         ld_col_ff <= '0;
         is_row_ff <= '0;
         is_col_ff <= '0;
         is_idx_ff <= '0;
      end else begin
         state_ff  <= state_in;
         ld_row_ff <= ld_row_in;
         ld_col_ff <= ld_col_in;
         is_row_ff <= is_row_in;
         is_col_ff <= is_col_in;
         is_idx_ff <= is_idx_in;
      end
   end

   // head of the chain
   assign ctl_chain[0].valid = (state_ff == ST_RUN);
   assign ctl_chain[0].last  = issue_last;
   assign row_chain[0]       = is_row_ff;
   assign col_chain[0]       = is_col_ff;
   assign idx_chain[0]       = is_idx_ff;
   assign sum_chain[0]       = '0;

   for (genvar g = 0; g < MATRIX_DIM; g++) begin : g_cell
      m4mul_cell #(
         .ELEMENT_WIDTH (ELEMENT_WIDTH),
         .MATRIX_DIM    (MATRIX_DIM),
         .CELL_ID       (g)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .wr_en   (req_take),
         .wr_row  (ld_row_ff),
         .wr_col  (ld_col_ff),
         .wr_a    (a_word),
         .wr_b    (b_word),
         .in_ctl  (ctl_chain[g]),
         .in_row  (row_chain[g]),
         .in_col  (col_chain[g]),
         .in_idx  (idx_chain[g]),
         .in_sum  (sum_chain[g]),
         .out_ctl (ctl_chain[g+1]),
         .out_row (row_chain[g+1]),
         .out_col (col_chain[g+1]),
         .out_idx (idx_chain[g+1]),
         .out_sum (sum_chain[g+1])
      );
   end

   // scale back to Q format and clip
   assign shifted  = sum_chain[MATRIX_DIM] >>> FRACTION_BITS;
   assign fits     = (&shifted[SUM_W-1:ELEMENT_WIDTH-1]) ||
                     !(|shifted[SUM_W-1:ELEMENT_WIDTH-1]);
   assign clip_val = shifted[SUM_W-1] ? {1'b1, {(ELEMENT_WIDTH-1){1'b0}}}
                                      : {1'b0, {(ELEMENT_WIDTH-1){1'b1}}};
   assign rsp_prod_in  = fits ? shifted[ELEMENT_WIDTH-1:0] : clip_val;
   assign rsp_sat_in   = !fits;
   assign rsp_valid_in = adv ? ctl_chain[MATRIX_DIM].valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_prod_ff <= rsp_prod_in;
         rsp_idx_ff  <= idx_chain[MATRIX_DIM];
         rsp_sat_ff  <= rsp_sat_in;
         rsp_last_ff <= ctl_chain[MATRIX_DIM].last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_W'({rsp_idx_ff, rsp_prod_ff});
   assign rsp_tuser  = rsp_sat_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

[rtl/core/m4mul_cell.sv]
// m4mul_cell: one multiply-accumulate cell of the product chain.
// Holds column CELL_ID of A and row CELL_ID of B; depends on m4mul_pkg.

module m4mul_cell #(
   parameter int ELEMENT_WIDTH = 32,
   parameter int MATRIX_DIM    = 4,
   parameter int CELL_ID       = 0
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              adv,
   // element load
   input  logic                                              wr_en,
   input  logic [$clog2(MATRIX_DIM)-1:0]                     wr_row,
   input  logic [$clog2(MATRIX_DIM)-1:0]                     wr_col,
   input  logic signed [ELEMENT_WIDTH-1:0]                   wr_a,
   input  logic signed [ELEMENT_WIDTH-1:0]                   wr_b,
   // chain input from the left neighbor
   input  m4mul_pkg::cell_ctl_type                           in_ctl,
   input  logic [$clog2(MATRIX_DIM)-1:0]                     in_row,
   input  logic [$clog2(MATRIX_DIM)-1:0]                     in_col,
   input  logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0]          in_idx,
   input  logic signed [2*ELEMENT_WIDTH+$clog2(MATRIX_DIM)-1:0] in_sum,
   // chain output to the right neighbor
   output m4mul_pkg::cell_ctl_type                           out_ctl,
   output logic [$clog2(MATRIX_DIM)-1:0]                     out_row,
   output logic [$clog2(MATRIX_DIM)-1:0]                     out_col,
   output logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0]          out_idx,
   output logic signed [2*ELEMENT_WIDTH+$clog2(MATRIX_DIM)-1:0] out_sum
);

   localparam int ROW_W  = $clog2(MATRIX_DIM);
   localparam int IDX_W  = $clog2(MATRIX_DIM*MATRIX_DIM);
   localparam int PROD_W = 2*ELEMENT_WIDTH;
   localparam int SUM_W  = PROD_W + $clog2(MATRIX_DIM);
   localparam logic [ROW_W-1:0] MY_ID = ROW_W'(CELL_ID);

   // A[r][CELL_ID] at entry r, B[CELL_ID][c] at entry c
   logic signed [ELEMENT_WIDTH-1:0] a_col_ff [MATRIX_DIM];
   logic signed [ELEMENT_WIDTH-1:0] b_row_ff [MATRIX_DIM];

   m4mul_pkg::cell_ctl_type         p_ctl_ff, p_ctl_in;
   logic [ROW_W-1:0]                p_row_ff, p_col_ff;
   logic [IDX_W-1:0]                p_idx_ff;
   logic signed [SUM_W-1:0]         p_sum_ff;
   logic signed [PROD_W-1:0]        product_ff, product_in;

   m4mul_pkg::cell_ctl_type         s_ctl_ff;
   logic [ROW_W-1:0]                s_row_ff, s_col_ff;
   logic [IDX_W-1:0]                s_idx_ff;
   logic signed [SUM_W-1:0]         s_sum_ff, s_sum_in;

   always_ff @(posedge clock) begin
      if (wr_en && (wr_col == MY_ID)) begin
         a_col_ff[wr_row] <= wr_a;
      end
      if (wr_en && (wr_row == MY_ID)) begin
         b_row_ff[wr_col] <= wr_b;
      end
   end

   assign product_in = a_col_ff[in_row] * b_row_ff[in_col];
   assign p_ctl_in   = in_ctl;
   assign s_sum_in   = p_sum_ff + {{(SUM_W-PROD_W){product_ff[PROD_W-1]}}, product_ff};

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         p_ctl_ff <= '0;
         s_ctl_ff <= '0;
      end else if (adv) begin
         p_ctl_ff <= p_ctl_in;
         s_ctl_ff <= p_ctl_ff;
      end
   end

   // payload: multiply stage, then accumulate stage
   always_ff @(posedge clock) begin
      if (adv) begin
         product_ff <= product_in;
         p_sum_ff   <= in_sum;
         p_row_ff   <= in_row;
         p_col_ff   <= in_col;
         p_idx_ff   <= in_idx;
         s_sum_ff   <= s_sum_in;
         s_row_ff   <= p_row_ff;
         s_col_ff   <= p_col_ff;
         s_idx_ff   <= p_idx_ff;
      end
   end

   assign out_ctl = s_ctl_ff;
   assign out_row = s_row_ff;
   assign out_col = s_col_ff;
   assign out_idx = s_idx_ff;
   assign out_sum = s_sum_ff;

endmodule

[rtl/core/m4mul_checker.sv]
// m4mul_checker: port-level checks for mat4_multiply, bound to the top level.
// Depends only on the ports of mat4_multiply.

module m4mul_checker #(
   parameter int ELEMENT_WIDTH = 32,
   parameter int MATRIX_DIM    = 4
) (
   input logic                                                  clock,
   input logic                                                  reset,
   input logic                                                  req_tvalid,
   input logic                                                  req_tready,
   input logic                                                  req_tlast,
   input logic                                                  rsp_tvalid,
   input logic                                                  rsp_tready,
   input logic [((ELEMENT_WIDTH+$clog2(MATRIX_DIM*MATRIX_DIM)+7)/8)*8-1:0] rsp_tdata,
   input logic                                                  rsp_tuser,
   input logic                                                  rsp_tlast
);

   localparam int IDX_W = $clog2(MATRIX_DIM*MATRIX_DIM);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MATRIX_DIM*MATRIX_DIM-1);
   localparam logic [ELEMENT_WIDTH-1:0] MAX_VAL = {1'b0, {(ELEMENT_WIDTH-1){1'b1}}};
   localparam logic [ELEMENT_WIDTH-1:0] MIN_VAL = {1'b1, {(ELEMENT_WIDTH-1){1'b0}}};

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("rsp word changed while stalled");

   // the last load word closes the input
   a_load_closes: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("input still open after last word");

   // a clipped element sits at a range limit
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         rsp_tdata[ELEMENT_WIDTH-1:0] == MAX_VAL || rsp_tdata[ELEMENT_WIDTH-1:0] == MIN_VAL)
      else $error("saturated flag on an unclipped value");

   // end of matrix only on the final index
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[ELEMENT_WIDTH+IDX_W-1:ELEMENT_WIDTH] == LAST_IDX)
      else $error("tlast on wrong element index");

endmodule

bind mat4_multiply m4mul_checker #(
   .ELEMENT_WIDTH (ELEMENT_WIDTH),
   .MATRIX_DIM    (MATRIX_DIM)
) u_m4mul_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

[tb/mat4_product_checker.sv]
`timescale 1ns / 100ps
// mat4_product_checker: watches the req_/rsp_ streams of mat4_multiply, keeps its own
// copy of both element stores, predicts each product word and compares field by field.
// Standalone; needs only the port layout of mat4_multiply.

module mat4_product_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,       // a_element, b_element
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,       // product_element, element_index
   input  logic        rsp_tuser,       // saturated
   input  logic        rsp_tlast,
   output int          mismatches,
   output int          results_pending
);

   localparam int FRAC_BITS = 16;
   localparam int DIM       = 4;

   // Q16.16 limits held at accumulator width
   localparam logic signed [67:0] Q_MAX = 68'sh0_7FFF_FFFF;
   localparam logic signed [67:0] Q_MIN = ~Q_MAX;

   typedef struct {
      logic signed [31:0] value;
      logic [3:0]         index;
      logic               saturated;
      logic               end_of_matrix;
   } product_word_type;

   logic signed [31:0] left_elems [16];
   logic signed [31:0] right_elems [16];
   logic [3:0]         load_position;
   product_word_type   expected_words [$];
   product_word_type   want;

   initial begin
      mismatches      = 0;
      results_pending = 0;
   end

   task automatic report_mismatch(input string what, input longint got, input longint wanted);
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, wanted);
      mismatches++;
   endtask

   // Full product A*B, column-major; exact sum, then arithmetic shift, then clip.
   function automatic void predict_product_matrix();
      logic signed [67:0] acc;
      logic signed [67:0] shifted;
      product_word_type   word;
      int                 col;
      int                 row;
      for (int k = 0; k < DIM * DIM; k++) begin
         col = k / DIM;
         row = k % DIM;
         acc = '0;
         for (int j = 0; j < DIM; j++)
            acc = acc + left_elems[j*DIM + row] * right_elems[col*DIM + j];
         shifted = acc >>> FRAC_BITS;
         word.saturated = 1'b1;
         if (shifted > Q_MAX)
            word.value = Q_MAX[31:0];
         else if (shifted < Q_MIN)
            word.value = Q_MIN[31:0];
         else begin
            word.value     = shifted[31:0];
            word.saturated = 1'b0;
         end
         word.index         = 4'(k);
         word.end_of_matrix = (k == DIM * DIM - 1);
         expected_words.push_back(word);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_words.delete();
         load_position = '0;
         results_pending <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               report_mismatch("product word with nothing expected",
                               $signed(rsp_tdata[31:0]), 0);
            end else begin
               want = expected_words.pop_front();
               if (rsp_tdata[31:0] !== want.value)
                  report_mismatch($sformatf("product_element [%0d]", want.index),
                                  $signed(rsp_tdata[31:0]), want.value);
               if (rsp_tdata[35:32] !== want.index)
                  report_mismatch("element_index", rsp_tdata[35:32], want.index);
               if (rsp_tuser !== want.saturated)
                  report_mismatch($sformatf("saturated [%0d]", want.index),
                                  rsp_tuser, want.saturated);
               if (rsp_tlast !== want.end_of_matrix)
                  report_mismatch($sformatf("end_of_matrix [%0d]", want.index),
                                  rsp_tlast, want.end_of_matrix);
            end
         end
         if (req_tvalid && req_tready) begin
            left_elems[load_position]  = req_tdata[31:0];
            right_elems[load_position] = req_tdata[63:32];
            if (req_tlast) begin
               predict_product_matrix();
               load_position = '0;
            end else begin
               load_position = load_position + 4'd1;   // wraps past the last entry
            end
         end
         results_pending <= expected_words.size();
      end
   end

endmodule

[tb/tb_mat4_multiply.sv]
`timescale 1ns / 100ps
// tb_mat4_multiply: stimulus and verdict for mat4_multiply.
// Depends on mat4_multiply and mat4_product_checker, which does the product checking.

module tb_mat4_multiply;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;       // a_element, b_element
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;             // product_element, element_index
   logic        rsp_tuser;             // saturated
   logic        rsp_tlast;

   int mismatches;
   int results_pending;
   int send_idle_pct = 31;
   int recv_idle_pct = 83;
   int words_sent    = 0;

   mat4_multiply dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   mat4_product_checker product_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .mismatches      (mismatches),
      .results_pending (results_pending)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      #200000;
      $display("FAIL");
      $finish;
   end

   // One word: random idle gap, then hold until accepted.
   task automatic send_word(input logic [31:0] a_elem, input logic [31:0] b_elem,
                            input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b_elem, a_elem};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   // flavor 0: moderate values that mostly stay in range; 1: full range; 2: corner mix
   function automatic logic [31:0] pick_element(input int flavor);
      case (flavor)
         0: return 32'($urandom_range(0, 2**21 - 1)) - 32'h0010_0000;
         1: return $urandom();
         default: begin
            case ($urandom_range(7))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               3: return $urandom_range(1) ? 32'h0001_0000 : 32'hFFFF_0000;
               4: return 32'($urandom_range(0, 8)) - 32'd4;
               default: return $urandom();
            endcase
         end
      endcase
   endfunction

   task automatic send_run(input int length, input logic mark_last, input int flavor);
      for (int i = 0; i < length; i++)
         send_word(pick_element(flavor), pick_element(flavor), mark_last && i == length - 1);
   endtask

   // Mostly whole batches; some end early, some run past sixteen and wrap.
   task automatic run_random(input int goal, input logic force_wrap);
      int start;
      int pick;
      start = words_sent;
      if (force_wrap)
         send_run($urandom_range(17, 24), 1'b0, 2);
      while (words_sent - start < goal) begin
         pick = $urandom_range(99);
         if (pick < 70)
            send_run(16, 1'b1, $urandom_range(2));
         else if (pick < 85)
            send_run($urandom_range(1, 15), 1'b1, $urandom_range(2));
         else
            send_run($urandom_range(17, 24), 1'b0, $urandom_range(2));
      end
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
   endtask

   initial begin
      logic [31:0] a_elem;
      logic [31:0] b_elem;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // First batch fills every entry: extremes, signs, fractions.
      for (int i = 0; i < 16; i++) begin
         case (i)
            0:  {a_elem, b_elem} = {32'h7FFF_FFFF, 32'h7FFF_FFFF};
            1:  {a_elem, b_elem} = {32'h8000_0000, 32'h8000_0000};
            2:  {a_elem, b_elem} = {32'h0001_0000, 32'hFFFF_0000};
            3:  {a_elem, b_elem} = {32'hFFFF_FFFF, 32'h0000_0001};
            4:  {a_elem, b_elem} = {32'h7FFF_FFFF, 32'h8000_0000};
            5:  {a_elem, b_elem} = {32'h0000_0000, 32'h7FFF_FFFF};
            6:  {a_elem, b_elem} = {32'h0000_8000, 32'h0001_8000};
            7:  {a_elem, b_elem} = {32'h8000_0000, 32'h0000_0000};
            8:  {a_elem, b_elem} = {32'hFFFF_0000, 32'hFFFF_0000};
            9:  {a_elem, b_elem} = {32'h1234_5678, 32'h8765_4321};
            10: {a_elem, b_elem} = {32'h0000_0001, 32'hFFFF_FFFF};
            11: {a_elem, b_elem} = {32'h7FFF_FFFF, 32'h0001_0000};
            12: {a_elem, b_elem} = {32'h8000_0000, 32'h0001_0000};
            13: {a_elem, b_elem} = {32'h0002_0000, 32'hFFFE_0000};
            14: {a_elem, b_elem} = {32'h5555_5555, 32'hAAAA_AAAA};
            default: {a_elem, b_elem} = {32'h0000_0000, 32'h0000_0000};
         endcase
         send_word(a_elem, b_elem, i == 15);
      end
      // early last mark on the very first entry, then after five entries
      send_word(32'h0001_0000, 32'h0002_0000, 1'b1);
      send_run(5, 1'b1, 2);
      wait_for_results();

      run_random(26, 1'b1);
      send_idle_pct = 83;
      recv_idle_pct <= 31;
      run_random(26, 1'b0);
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      run_random(26, 1'b0);

      wait_for_results();
      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
